/* rtl/bli_pkg.sv */
// Shared types, codes and the microprogram of the breakpoint interpolator.
// Used by the sequencer and the top level; depends on nothing.
package bli_pkg;

    typedef logic [4:0] step_t;

    // Datapath operation carried by each control word
    typedef enum logic [4:0] {
        OP_ACCEPT,
        OP_RD_PREV,
        OP_LOAD_FIN,
        OP_RD_FIRST,
        OP_CHK_LO,
        OP_CHK_HI,
        OP_SRCH_ADDR,
        OP_SRCH_STEP,
        OP_PICK_B,
        OP_LATCH_A,
        OP_LATCH_B,
        OP_DIFF,
        OP_MUL,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_SUM,
        OP_EMIT
    } op_t;

    // Jump condition; a true condition loads the target, else the step advances
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_EVAL,
        C_LE_RD,
        C_GE_RD,
        C_SRCH_END,
        C_DEN_BAD,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // Condition inputs from the datapath to the sequencer
    typedef struct packed {
        logic no_req;
        logic eval;
        logic le_rd;
        logic ge_rd;
        logic srch_end;
        logic den_bad;
        logic div_busy;
        logic out_busy;
    } cond_flags_t;

    localparam step_t STEP_DECODE    = 5'd0;
    localparam step_t STEP_LOAD_FIN  = 5'd1;
    localparam step_t STEP_RD_FIRST  = 5'd2;
    localparam step_t STEP_CHK_LO    = 5'd3;
    localparam step_t STEP_CHK_HI    = 5'd4;
    localparam step_t STEP_SRCH_ADDR = 5'd5;
    localparam step_t STEP_SRCH_STEP = 5'd6;
    localparam step_t STEP_PICK_B    = 5'd7;
    localparam step_t STEP_LATCH_A   = 5'd8;
    localparam step_t STEP_LATCH_B   = 5'd9;
    localparam step_t STEP_DIFF      = 5'd10;
    localparam step_t STEP_MUL       = 5'd11;
    localparam step_t STEP_DIV_START = 5'd12;
    localparam step_t STEP_DIV_WAIT  = 5'd13;
    localparam step_t STEP_SUM       = 5'd14;
    localparam step_t STEP_EMIT      = 5'd15;
    localparam step_t STEP_IDLE      = 5'd16;
    localparam step_t STEP_LAST      = STEP_IDLE;

    function automatic ctrl_t ucode_rom(step_t pc);
        ctrl_t w;
        unique case (pc)
            STEP_DECODE:    w = '{op: OP_RD_PREV,   cond: C_EVAL,     target: STEP_RD_FIRST};
            STEP_LOAD_FIN:  w = '{op: OP_LOAD_FIN,  cond: C_ALWAYS,   target: STEP_EMIT};
            STEP_RD_FIRST:  w = '{op: OP_RD_FIRST,  cond: C_NEVER,    target: STEP_DECODE};
            STEP_CHK_LO:    w = '{op: OP_CHK_LO,    cond: C_LE_RD,    target: STEP_EMIT};
            STEP_CHK_HI:    w = '{op: OP_CHK_HI,    cond: C_GE_RD,    target: STEP_EMIT};
            STEP_SRCH_ADDR: w = '{op: OP_SRCH_ADDR, cond: C_SRCH_END, target: STEP_PICK_B};
            STEP_SRCH_STEP: w = '{op: OP_SRCH_STEP, cond: C_ALWAYS,   target: STEP_SRCH_ADDR};
            STEP_PICK_B:    w = '{op: OP_PICK_B,    cond: C_NEVER,    target: STEP_DECODE};
            STEP_LATCH_A:   w = '{op: OP_LATCH_A,   cond: C_NEVER,    target: STEP_DECODE};
            STEP_LATCH_B:   w = '{op: OP_LATCH_B,   cond: C_NEVER,    target: STEP_DECODE};
            STEP_DIFF:      w = '{op: OP_DIFF,      cond: C_DEN_BAD,  target: STEP_EMIT};
            STEP_MUL:       w = '{op: OP_MUL,       cond: C_NEVER,    target: STEP_DECODE};
            STEP_DIV_START: w = '{op: OP_DIV_START, cond: C_NEVER,    target: STEP_DECODE};
            STEP_DIV_WAIT:  w = '{op: OP_DIV_WAIT,  cond: C_DIV_BUSY, target: STEP_DIV_WAIT};
            STEP_SUM:       w = '{op: OP_SUM,       cond: C_NEVER,    target: STEP_DECODE};
            STEP_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: STEP_EMIT};
            STEP_IDLE:      w = '{op: OP_ACCEPT,    cond: C_NO_REQ,   target: STEP_IDLE};
            default:        w = '{op: OP_DIV_WAIT,  cond: C_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/bli_div.sv */
// Restoring divider, one quotient bit per cycle, 40 quotient bits.
// Quotients of 2^40 and above report as 2^40. Standalone, no package.
module bli_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [40:0] quot
);

    localparam int QBITS = 40;
    localparam logic [5:0] STEPS = 6'(QBITS);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [QBITS-1:0] quo_reg, quo_next;
    logic        ovf_reg, ovf_next;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    assign trial = {rem_reg, quo_reg[QBITS-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = trial >= {1'b0, den};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            // top bits alone already reach den: quotient is at least 2^40
            ovf_next  = {8'b0, num[63:QBITS]} >= den;
            rem_next  = {8'b0, num[63:QBITS]};
            quo_next  = num[QBITS-1:0];
            cnt_next  = STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[31:0] : trial[31:0];
            quo_next  = {quo_reg[QBITS-2:0], fits};
            cnt_next  = cnt_reg - 6'd1;
            busy_next = cnt_reg != 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign busy = busy_reg;
    assign quot = ovf_reg ? {1'b1, {QBITS{1'b0}}} : {1'b0, quo_reg};

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(cnt_reg) == 6'd1)
        else $error("divider finished before all quotient bits");

endmodule

/* rtl/bli_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Uses bli_pkg for the control word, condition codes and the program.
module bli_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bli_pkg::cond_flags_t flags,
    output bli_pkg::op_t         op
);
    import bli_pkg::*;

    step_t pc_reg, pc_next;
    ctrl_t word;
    logic  taken;

    assign word = ucode_rom(pc_reg);
    assign op   = word.op;

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_REQ:   taken = flags.no_req;
            C_EVAL:     taken = flags.eval;
            C_LE_RD:    taken = flags.le_rd;
            C_GE_RD:    taken = flags.ge_rd;
            C_SRCH_END: taken = flags.srch_end;
            C_DEN_BAD:  taken = flags.den_bad;
            C_DIV_BUSY: taken = flags.div_busy;
            C_OUT_BUSY: taken = flags.out_busy;
            default:    taken = 1'b0;
        endcase
    end

    // the last step wraps to the first
    always_comb
    begin
        if (taken)
            pc_next = word.target;
        else if (pc_reg == STEP_LAST)
            pc_next = STEP_DECODE;
        else
            pc_next = pc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= STEP_LAST)
        else $error("step counter left the program");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (word.op == OP_ACCEPT && !flags.no_req) |=> pc_reg == STEP_DECODE)
        else $error("accepted request not decoded next");

endmodule

/* rtl/breakpoint_linear_interpolator.sv */
// Piecewise linear interpolator over up to MAX_POINTS breakpoints (signed Q16.16). A load
// request writes one breakpoint and is answered with a status; an evaluate request clamps
// to the end values or binary-searches the table and interpolates, saturating to Q16.16.
// One request at a time runs through a microprogram. An evaluate that does not clamp runs
// a binary search, each step of which reads the table through its single read port, and
// then divides in the bit-serial divider. A finished result waits in the output register
// while the next request is taken. Uses bli_pkg, bli_seq and bli_div.
module breakpoint_linear_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // entry_index[5:0], x_value[37:6], y_value[69:38]
    input  logic        s_tuser,   // mode (0 load, 1 evaluate)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // y_result[31:0], status[33:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // point_count
);
    import bli_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > 7) ? NW : 7;

    op_t         op;
    cond_flags_t flags;

    // configuration
    logic [6:0] point_count_reg;

    // request and working registers
    logic               mode_reg, mode_next;
    logic [5:0]         idx_reg, idx_next;
    logic signed [31:0] xq_reg, xq_next;
    logic [31:0]        yin_reg, yin_next;
    logic [NW-1:0]      lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [NW-1:0]      b_reg, b_next;
    logic signed [31:0] xa_reg, xa_next, xb_reg, xb_next;
    logic signed [31:0] ya_reg, ya_next, yb_reg, yb_next;
    logic [31:0]        mdy_reg, mdy_next, mdx_reg, mdx_next, den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [63:0]        prod_reg, prod_next;
    logic [31:0]        res_y_reg, res_y_next;
    status_t            res_st_reg, res_st_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_y_reg, out_y_next;
    status_t     out_st_reg, out_st_next;

    // table memory
    logic [31:0]        x_mem [MAX_POINTS];
    logic [31:0]        y_mem [MAX_POINTS];
    logic signed [31:0] rd_x_reg;
    logic [31:0]        rd_y_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;

    logic [CW-1:0] pcount_ext, n_w, idx_ext;
    logic [NW-1:0] n_c, nm1_c, mid_c, b_lo, b_c;
    logic [NW:0]   lohi_sum;
    logic [AW-1:0] idx_addr;
    status_t       load_st;

    logic signed [32:0] dy_c, dx_c, den_c;
    logic [63:0]        mul_c;
    logic               div_busy;
    logic [40:0]        div_quot;
    logic signed [41:0] qs_c, sum_c;
    logic [31:0]        sat_c;
    logic               out_busy, emit_go;

    // active count, kept within 1..MAX_POINTS
    assign pcount_ext = CW'(point_count_reg);
    assign n_w = (pcount_ext == '0) ? CW'(1) :
                 (pcount_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pcount_ext;
    assign n_c   = n_w[NW-1:0];
    assign nm1_c = n_c - NW'(1);

    assign idx_ext  = CW'(idx_reg);
    assign idx_addr = idx_ext[AW-1:0];

    assign load_st = (idx_ext >= n_w) ? ST_RANGE :
                     (idx_reg != 6'd0 && xq_reg <= rd_x_reg) ? ST_ORDER : ST_OK;

    assign lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c    = lohi_sum[NW:1];

    // found slot kept within 1..n-1
    assign b_lo = (lo_reg == '0) ? NW'(1) : lo_reg;
    assign b_c  = (b_lo > nm1_c) ? nm1_c : b_lo;

    assign dy_c  = {yb_reg[31], yb_reg} - {ya_reg[31], ya_reg};
    assign dx_c  = {xq_reg[31], xq_reg} - {xa_reg[31], xa_reg};
    assign den_c = {xb_reg[31], xb_reg} - {xa_reg[31], xa_reg};

    assign mul_c = mdy_reg * mdx_reg;

    assign qs_c  = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign sum_c = {{10{ya_reg[31]}}, ya_reg} + qs_c;
    assign sat_c = (sum_c[41:31] == '0 || sum_c[41:31] == '1) ? sum_c[31:0] :
                   (sum_c[41] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign out_busy = out_valid_reg && !m_tready;
    assign emit_go  = (op == OP_EMIT) && !out_busy;
    assign mem_we   = (op == OP_LOAD_FIN) && (load_st == ST_OK);

    always_comb
    begin
        unique case (op)
            OP_RD_PREV:   rd_addr = idx_addr - AW'(1);
            OP_RD_FIRST:  rd_addr = '0;
            OP_CHK_LO:    rd_addr = nm1_c[AW-1:0];
            OP_SRCH_ADDR: rd_addr = mid_c[AW-1:0];
            OP_PICK_B:    rd_addr = nm1_c == '0 ? '0 : AW'(b_c - NW'(1));
            OP_LATCH_A:   rd_addr = b_reg[AW-1:0];
            default:      rd_addr = '0;
        endcase
    end

    assign flags.no_req   = !s_tvalid;
    assign flags.eval     = mode_reg;
    assign flags.le_rd    = xq_reg <= rd_x_reg;
    assign flags.ge_rd    = xq_reg >= rd_x_reg;
    assign flags.srch_end = lo_reg >= hi_reg;
    assign flags.den_bad  = den_c[32] || (den_c == '0);
    assign flags.div_busy = div_busy;
    assign flags.out_busy = out_busy;

    always_comb
    begin
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        xq_next     = xq_reg;
        yin_next    = yin_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        b_next      = b_reg;
        xa_next     = xa_reg;
        ya_next     = ya_reg;
        xb_next     = xb_reg;
        yb_next     = yb_reg;
        mdy_next    = mdy_reg;
        mdx_next    = mdx_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        res_y_next  = res_y_reg;
        res_st_next = res_st_reg;
        unique case (op)
            OP_ACCEPT:
            begin
                if (s_tvalid)
                begin
                    mode_next = s_tuser;
                    idx_next  = s_tdata[5:0];
                    xq_next   = s_tdata[37:6];
                    yin_next  = s_tdata[69:38];
                end
            end
            OP_LOAD_FIN:
            begin
                res_y_next  = '0;
                res_st_next = load_st;
            end
            OP_CHK_LO:
            begin
                res_y_next  = rd_y_reg;
                res_st_next = ST_OK;
            end
            OP_CHK_HI:
            begin
                res_y_next = rd_y_reg;
                lo_next    = '0;
                hi_next    = n_c;
            end
            OP_SRCH_ADDR:
            begin
                mid_next = mid_c;
            end
            OP_SRCH_STEP:
            begin
                if (rd_x_reg < xq_reg)
                    lo_next = mid_reg + NW'(1);
                else
                    hi_next = mid_reg;
            end
            OP_PICK_B:
            begin
                b_next = b_c;
            end
            OP_LATCH_A:
            begin
                xa_next = rd_x_reg;
                ya_next = rd_y_reg;
            end
            OP_LATCH_B:
            begin
                xb_next = rd_x_reg;
                yb_next = rd_y_reg;
            end
            OP_DIFF:
            begin
                // a non-positive span answers ya
                res_y_next = ya_reg;
                mdy_next   = dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
                mdx_next   = dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
                neg_next   = dy_c[32] ^ dx_c[32];
                den_next   = den_c[31:0];
            end
            OP_MUL:
            begin
                prod_next = mul_c;
            end
            OP_SUM:
            begin
                res_y_next = sat_c;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_y_next     = out_y_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg;
        if (emit_go)
        begin
            out_y_next     = res_y_reg;
            out_st_next    = res_st_reg;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 7'd1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                point_count_reg <= cfg_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        idx_reg    <= idx_next;
        xq_reg     <= xq_next;
        yin_reg    <= yin_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        b_reg      <= b_next;
        xa_reg     <= xa_next;
        ya_reg     <= ya_next;
        xb_reg     <= xb_next;
        yb_reg     <= yb_next;
        mdy_reg    <= mdy_next;
        mdx_reg    <= mdx_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        res_y_reg  <= res_y_next;
        res_st_reg <= res_st_next;
        out_y_reg  <= out_y_next;
        out_st_reg <= out_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[idx_addr] <= xq_reg;
            y_mem[idx_addr] <= yin_reg;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    bli_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    bli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (op == OP_DIV_START),
        .num   (prod_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign s_tready  = (op == OP_ACCEPT);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'b0, out_st_reg, out_y_reg};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in work");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(op == OP_EMIT))
        else $error("result shown outside the emit step");

endmodule
